// ===== rtl/core/wfpa_pkg.sv =====
// Shared constants, types and state codes of the wide fixed-point ALU.
// No dependencies; every other file of the block but wfpa_ram refers to this package.
package wfpa_pkg;

  localparam int LIMB_W     = 64;
  localparam int DIG_W      = 32;
  localparam int FRAC_LIMBS = 30;
  localparam int NLIMBS     = FRAC_LIMBS + 1;
  localparam int LIDX_W     = $clog2(NLIMBS);
  localparam int CNT_W      = $clog2(NLIMBS + 1);
  localparam int NDIG       = 2 * NLIMBS;
  localparam int DIDX_W     = $clog2(NDIG);
  localparam int COL_LAST   = 2 * NDIG - 2;
  localparam int COL_W      = $clog2(COL_LAST + 1);
  localparam int ACC_W      = 2 * DIG_W + DIDX_W + 2;
  // product digits below this column fall under the last fraction limb
  localparam int KEEP_COL   = 2 * FRAC_LIMBS;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_MUL  = 2'd1,
    ACT_SQR  = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_ADD,
    B_MUL,
    B_OUT
  } bst_t;

  typedef struct packed {
    act_t action;
    logic sign_a;
    logic sign_b;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } bstat_t;

endpackage

// ===== rtl/core/wfpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/wfpa_front.sv =====
// Front end: takes operand limbs, writes the operand stores, and queues
// one command per last item unless its action is ACT_NONE. Uses wfpa_pkg.
module wfpa_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_action,
  input  logic                          in_sign_a,
  input  logic                          in_sign_b,
  input  logic [wfpa_pkg::LIMB_W-1:0]   in_limb_a,
  input  logic [wfpa_pkg::LIMB_W-1:0]   in_limb_b,
  input  logic                          in_last_limb,
  input  logic                          q_empty,
  input  wfpa_pkg::bstat_t              bstat,
  output logic                          op_we,
  output logic [wfpa_pkg::LIDX_W-1:0]   op_waddr,
  output logic [wfpa_pkg::LIMB_W-1:0]   op_wdata_a,
  output logic [wfpa_pkg::LIMB_W-1:0]   op_wdata_b,
  output logic                          cmd_push,
  output wfpa_pkg::cmd_t                cmd
);

  logic [wfpa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       acc;
  logic                       room;

  // operands are held until the back end has finished reading them
  assign full = !q_empty || bstat.busy;
  assign acc  = push && !full;
  assign room = cnt_r < wfpa_pkg::CNT_W'(wfpa_pkg::NLIMBS);

  assign op_we      = acc && room;
  assign op_waddr   = cnt_r[wfpa_pkg::LIDX_W-1:0];
  assign op_wdata_a = in_limb_a;
  assign op_wdata_b = in_limb_b;

  assign cmd.action = wfpa_pkg::act_t'(in_action);
  assign cmd.sign_a = in_sign_a;
  assign cmd.sign_b = in_sign_b;
  assign cmd_push   = acc && in_last_limb && (cmd.action != wfpa_pkg::ACT_NONE);

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (in_last_limb) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/wfpa_cmdq.sv =====
// Two-entry command queue between front and back end.
// Uses wfpa_pkg.
module wfpa_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  wfpa_pkg::cmd_t wdata,
  input  logic           rd,
  output logic           q_empty,
  output wfpa_pkg::cmd_t head
);

  wfpa_pkg::cmd_t ent_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_wr, do_rd;

  assign q_empty = cnt_r == 2'd0;
  assign do_wr   = wr && (cnt_r != 2'd2);
  assign do_rd   = rd && !q_empty;
  assign head    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) begin
        wp_r <= !wp_r;
      end
      if (do_rd) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== rtl/core/wfpa_back.sv =====
// Back end: compare / add / subtract over limbs, product scanning multiply
// on one 32x32 multiplier, result store and output register.
// Uses wfpa_pkg and wfpa_ram.
module wfpa_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  wfpa_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output wfpa_pkg::bstat_t              bstat,
  output logic [wfpa_pkg::LIDX_W-1:0]   a_raddr,
  output logic [wfpa_pkg::LIDX_W-1:0]   b_raddr,
  input  logic [wfpa_pkg::LIMB_W-1:0]   a_rdata,
  input  logic [wfpa_pkg::LIMB_W-1:0]   b_rdata,
  input  logic [wfpa_pkg::LIMB_W-1:0]   a2_rdata,
  output logic                          empty,
  input  logic                          pop,
  output logic [wfpa_pkg::LIMB_W-1:0]   out_result_limb,
  output logic                          out_result_sign,
  output logic                          out_result_last
);

  localparam logic [wfpa_pkg::CNT_W-1:0]  NL_C   = wfpa_pkg::CNT_W'(wfpa_pkg::NLIMBS);
  localparam logic [wfpa_pkg::LIDX_W-1:0] LTOP   = wfpa_pkg::LIDX_W'(wfpa_pkg::NLIMBS - 1);
  localparam logic [wfpa_pkg::COL_W-1:0]  CLAST  = wfpa_pkg::COL_W'(wfpa_pkg::COL_LAST);
  localparam logic [wfpa_pkg::COL_W-1:0]  DTOP_C = wfpa_pkg::COL_W'(wfpa_pkg::NDIG - 1);
  localparam logic [wfpa_pkg::COL_W-1:0]  KEEP_C = wfpa_pkg::COL_W'(wfpa_pkg::KEEP_COL);

  wfpa_pkg::bst_t state_r, state_nxt;
  wfpa_pkg::cmd_t cmd_r;
  logic [wfpa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic dec_r, gte_r, cy_r;

  logic [wfpa_pkg::COL_W-1:0]  col_r;
  logic [wfpa_pkg::DIDX_W-1:0] i_r;
  logic iss_r;
  logic s1_v_r, s1_ha_r, s1_hb_r, s1_end_r;
  logic [wfpa_pkg::COL_W-1:0] s1_col_r;
  logic s2_v_r, s2_end_r;
  logic [wfpa_pkg::COL_W-1:0] s2_col_r;
  logic [2*wfpa_pkg::DIG_W-1:0] prod_r;
  logic [wfpa_pkg::ACC_W-1:0]   acc_r;
  logic [wfpa_pkg::DIG_W-1:0]   lo_r;

  logic [wfpa_pkg::CNT_W-1:0] oc_r;
  logic pend_r, plast_r, ov_r;
  logic [wfpa_pkg::LIMB_W-1:0] olimb_r;
  logic olast_r;

  logic                        r_we;
  logic [wfpa_pkg::LIDX_W-1:0] r_waddr, r_raddr;
  logic [wfpa_pkg::LIMB_W-1:0] r_wdata, r_rdata;

  logic start, sub, dvalid, pop_ok, rd_issue, fin, emit, end_now;
  logic [wfpa_pkg::LIMB_W-1:0] y_q, xo, yo;
  logic [wfpa_pkg::LIMB_W:0]   sum, diff;
  logic [wfpa_pkg::DIDX_W-1:0] ilo_nxt, ihi, j_idx;
  logic [wfpa_pkg::COL_W-1:0]  col_inc, dd;
  logic [wfpa_pkg::ACC_W-1:0]  s_acc;
  logic [wfpa_pkg::DIG_W-1:0]  da, db;

  wfpa_ram #(.WIDTH(wfpa_pkg::LIMB_W), .DEPTH(wfpa_pkg::NLIMBS)) u_res (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  assign start = (state_r == wfpa_pkg::B_IDLE) && !q_empty;
  assign q_pop = start;
  assign bstat.busy = (state_r == wfpa_pkg::B_CMP) || (state_r == wfpa_pkg::B_ADD) ||
                      (state_r == wfpa_pkg::B_MUL);
  assign sub    = cmd_r.sign_a != cmd_r.sign_b;
  assign dvalid = cnt_r != '0;
  assign y_q    = (cmd_r.action == wfpa_pkg::ACT_SQR) ? a2_rdata : b_rdata;
  // larger magnitude goes first when subtracting
  assign xo     = gte_r ? a_rdata : y_q;
  assign yo     = gte_r ? y_q : a_rdata;
  assign sum    = {1'b0, xo} + {1'b0, yo} + (wfpa_pkg::LIMB_W + 1)'(cy_r);
  assign diff   = {1'b0, xo} - {1'b0, yo} - (wfpa_pkg::LIMB_W + 1)'(cy_r);

  // column bounds for product scanning
  assign col_inc = col_r + 1'b1;
  assign ilo_nxt = (col_inc >= DTOP_C) ? wfpa_pkg::DIDX_W'(col_inc - DTOP_C) : '0;
  assign ihi     = (col_r < DTOP_C) ? wfpa_pkg::DIDX_W'(col_r) : DTOP_C[wfpa_pkg::DIDX_W-1:0];
  assign j_idx   = wfpa_pkg::DIDX_W'(col_r - wfpa_pkg::COL_W'(i_r));
  assign end_now = i_r == ihi;

  assign da    = s1_ha_r ? a_rdata[2*wfpa_pkg::DIG_W-1:wfpa_pkg::DIG_W]
                         : a_rdata[wfpa_pkg::DIG_W-1:0];
  assign db    = s1_hb_r ? y_q[2*wfpa_pkg::DIG_W-1:wfpa_pkg::DIG_W]
                         : y_q[wfpa_pkg::DIG_W-1:0];
  assign s_acc = acc_r + wfpa_pkg::ACC_W'(prod_r);
  // the final column lies above the integer limb and wraps away
  assign emit  = s2_v_r && s2_end_r && (s2_col_r >= KEEP_C) && (s2_col_r != CLAST);
  assign fin   = s2_v_r && s2_end_r && (s2_col_r == CLAST);
  assign dd    = s2_col_r - KEEP_C;

  assign pop_ok   = pop && ov_r;
  assign rd_issue = (state_r == wfpa_pkg::B_OUT) && (oc_r < NL_C) && !pend_r &&
                    (!ov_r || pop_ok);
  assign r_raddr  = oc_r[wfpa_pkg::LIDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfpa_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_head.action == wfpa_pkg::ACT_ADD) begin
            state_nxt = (q_head.sign_a != q_head.sign_b) ? wfpa_pkg::B_CMP : wfpa_pkg::B_ADD;
          end else begin
            state_nxt = wfpa_pkg::B_MUL;
          end
        end
      end
      wfpa_pkg::B_CMP: if (cnt_r == NL_C) state_nxt = wfpa_pkg::B_ADD;
      wfpa_pkg::B_ADD: if (cnt_r == NL_C) state_nxt = wfpa_pkg::B_OUT;
      wfpa_pkg::B_MUL: if (fin) state_nxt = wfpa_pkg::B_OUT;
      wfpa_pkg::B_OUT: begin
        if ((oc_r == NL_C) && !pend_r && !ov_r) state_nxt = wfpa_pkg::B_IDLE;
      end
      default: state_nxt = wfpa_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    a_raddr = '0;
    b_raddr = '0;
    r_we    = 1'b0;
    r_waddr = '0;
    r_wdata = '0;
    case (state_r)
      wfpa_pkg::B_IDLE: cnt_nxt = '0;
      wfpa_pkg::B_CMP: begin
        cnt_nxt = (cnt_r == NL_C) ? '0 : cnt_r + 1'b1;
        if (cnt_r < NL_C) begin
          a_raddr = cnt_r[wfpa_pkg::LIDX_W-1:0];
          b_raddr = cnt_r[wfpa_pkg::LIDX_W-1:0];
        end
      end
      wfpa_pkg::B_ADD: begin
        cnt_nxt = (cnt_r == NL_C) ? '0 : cnt_r + 1'b1;
        if (cnt_r < NL_C) begin
          a_raddr = LTOP - cnt_r[wfpa_pkg::LIDX_W-1:0];
          b_raddr = LTOP - cnt_r[wfpa_pkg::LIDX_W-1:0];
        end
        r_we    = dvalid;
        r_waddr = wfpa_pkg::LIDX_W'(NL_C - cnt_r);
        r_wdata = sub ? diff[wfpa_pkg::LIMB_W-1:0] : sum[wfpa_pkg::LIMB_W-1:0];
      end
      wfpa_pkg::B_MUL: begin
        a_raddr = LTOP - i_r[wfpa_pkg::DIDX_W-1:1];
        b_raddr = LTOP - j_idx[wfpa_pkg::DIDX_W-1:1];
        // two digits make one limb
        r_we    = emit && dd[0];
        r_waddr = LTOP - dd[wfpa_pkg::LIDX_W:1];
        r_wdata = {s_acc[wfpa_pkg::DIG_W-1:0], lo_r};
      end
      wfpa_pkg::B_OUT: cnt_nxt = '0;
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wfpa_pkg::B_IDLE;
      cnt_r   <= '0;
      iss_r   <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      oc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (start && (q_head.action != wfpa_pkg::ACT_ADD)) begin
        iss_r <= 1'b1;
      end else if (iss_r && end_now && (col_r == CLAST)) begin
        iss_r <= 1'b0;
      end
      s1_v_r <= iss_r;
      s2_v_r <= s1_v_r;
      pend_r <= rd_issue;
      if (pend_r) begin
        ov_r <= 1'b1;
      end else if (pop_ok) begin
        ov_r <= 1'b0;
      end
      if (state_r == wfpa_pkg::B_IDLE) begin
        oc_r <= '0;
      end else if (rd_issue) begin
        oc_r <= oc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= q_head;
      dec_r <= 1'b0;
      gte_r <= 1'b1;
      cy_r  <= 1'b0;
      col_r <= '0;
      i_r   <= '0;
      acc_r <= '0;
    end
    if ((state_r == wfpa_pkg::B_CMP) && dvalid && !dec_r) begin
      if (a_rdata > b_rdata) begin
        dec_r <= 1'b1;
        gte_r <= 1'b1;
      end else if (a_rdata < b_rdata) begin
        dec_r <= 1'b1;
        gte_r <= 1'b0;
      end
    end
    if ((state_r == wfpa_pkg::B_ADD) && dvalid) begin
      cy_r <= sub ? diff[wfpa_pkg::LIMB_W] : sum[wfpa_pkg::LIMB_W];
    end
    if (iss_r) begin
      s1_ha_r  <= i_r[0];
      s1_hb_r  <= j_idx[0];
      s1_end_r <= end_now;
      s1_col_r <= col_r;
      if (end_now) begin
        col_r <= col_inc;
        i_r   <= ilo_nxt;
      end else begin
        i_r <= i_r + 1'b1;
      end
    end
    if (s1_v_r) begin
      prod_r   <= da * db;
      s2_end_r <= s1_end_r;
      s2_col_r <= s1_col_r;
    end
    if (s2_v_r) begin
      acc_r <= s2_end_r ? (s_acc >> wfpa_pkg::DIG_W) : s_acc;
      if (emit && !dd[0]) begin
        lo_r <= s_acc[wfpa_pkg::DIG_W-1:0];
      end
    end
    if (rd_issue) begin
      plast_r <= oc_r == wfpa_pkg::CNT_W'(wfpa_pkg::NLIMBS - 1);
    end
    if (pend_r) begin
      olimb_r <= r_rdata;
      olast_r <= plast_r;
    end
  end

  assign empty           = !ov_r;
  assign out_result_limb = olimb_r;
  assign out_result_last = olast_r;
  always_comb begin
    case (cmd_r.action)
      wfpa_pkg::ACT_MUL: out_result_sign = cmd_r.sign_a ^ cmd_r.sign_b;
      wfpa_pkg::ACT_SQR: out_result_sign = 1'b0;
      default:           out_result_sign = (!sub || gte_r) ? cmd_r.sign_a : cmd_r.sign_b;
    endcase
  end

  a_mul_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == wfpa_pkg::B_MUL)) else $error("product stage outside multiply");
  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == wfpa_pkg::B_OUT)) else $error("result shown outside output phase");
  a_no_wr_out: assert property (@(posedge clk) disable iff (!rst_n)
    r_we |-> (state_r == wfpa_pkg::B_ADD || state_r == wfpa_pkg::B_MUL))
    else $error("result store written while streaming");
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wfpa_pkg::B_MUL && $past(state_r) == wfpa_pkg::B_IDLE) |-> iss_r)
    else $error("multiply entered without issuing");

endmodule

// ===== rtl/core/wide_fixed_point_alu_unit.sv =====
// Top level of the wide fixed-point ALU: front end, command queue, operand
// stores and back end. Uses wfpa_pkg, wfpa_ram, wfpa_front, wfpa_cmdq, wfpa_back.
//
// Operands are 31 limbs of 64 bits (one integer limb, 30 fraction limbs),
// sign-magnitude, loaded integer limb first at one item per cycle while full
// is low. The item with last_limb set starts the operation and the result
// comes out as 31 items, integer limb first. An add whose signs differ
// first runs a magnitude compare pass; multiply and square run
// 62x62 = 3844 digit products through the single 32x32 multiplier, one per
// cycle. Results then stream out from the result store, a limb at a time as
// pop takes them. New operand limbs are taken while a previous result
// streams out, but not while an operation is computing.
module wide_fixed_point_alu_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  in_action,
  input  logic                        in_sign_a,
  input  logic                        in_sign_b,
  input  logic [wfpa_pkg::LIMB_W-1:0] in_limb_a,
  input  logic [wfpa_pkg::LIMB_W-1:0] in_limb_b,
  input  logic                        in_last_limb,
  output logic                        empty,
  input  logic                        pop,
  output logic [wfpa_pkg::LIMB_W-1:0] out_result_limb,
  output logic                        out_result_sign,
  output logic                        out_result_last
);

  logic                        op_we, cmd_push, q_empty, q_pop;
  logic [wfpa_pkg::LIDX_W-1:0] op_waddr, a_raddr, b_raddr;
  logic [wfpa_pkg::LIMB_W-1:0] op_wdata_a, op_wdata_b, a_rdata, b_rdata, a2_rdata;
  wfpa_pkg::cmd_t              cmd, q_head;
  wfpa_pkg::bstat_t            bstat;

  wfpa_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_action(in_action), .in_sign_a(in_sign_a), .in_sign_b(in_sign_b),
    .in_limb_a(in_limb_a), .in_limb_b(in_limb_b), .in_last_limb(in_last_limb),
    .q_empty(q_empty), .bstat(bstat), .op_we(op_we), .op_waddr(op_waddr),
    .op_wdata_a(op_wdata_a), .op_wdata_b(op_wdata_b),
    .cmd_push(cmd_push), .cmd(cmd)
  );

  wfpa_cmdq u_cmdq (
    .clk(clk), .rst_n(rst_n), .wr(cmd_push), .wdata(cmd),
    .rd(q_pop), .q_empty(q_empty), .head(q_head)
  );

  wfpa_ram #(.WIDTH(wfpa_pkg::LIMB_W), .DEPTH(wfpa_pkg::NLIMBS)) u_ram_a (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata_a),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  wfpa_ram #(.WIDTH(wfpa_pkg::LIMB_W), .DEPTH(wfpa_pkg::NLIMBS)) u_ram_b (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata_b),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  // copy of a, so a square reads two limbs of a in one cycle
  wfpa_ram #(.WIDTH(wfpa_pkg::LIMB_W), .DEPTH(wfpa_pkg::NLIMBS)) u_ram_a2 (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata_a),
    .raddr(b_raddr), .rdata(a2_rdata)
  );

  wfpa_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .bstat(bstat), .a_raddr(a_raddr), .b_raddr(b_raddr),
    .a_rdata(a_rdata), .b_rdata(b_rdata), .a2_rdata(a2_rdata),
    .empty(empty), .pop(pop), .out_result_limb(out_result_limb),
    .out_result_sign(out_result_sign), .out_result_last(out_result_last)
  );

endmodule
